[hdl/button_press_classifier_unit_defines.svh]
// Assertion macros for the button press classifier.
// Used by the top level only; no other dependencies.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bpc_pkg.sv]
// Shared types, widths and reset constants for the button press classifier.
// No dependencies; design files use scoped names, the benches import it.
`default_nettype none

package bpc_pkg;

  localparam int KEYS_DEFAULT = 8;
  localparam int KEY_W        = 3;
  localparam int TICK_W       = 16;
  localparam int CLICK_W      = 8;
  localparam int CODE_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd2;
  localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd50;
  localparam logic [TICK_W-1:0] GAP_TICKS_RST   = 16'd30;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SHORT  = 2'd1,
    PH_LONG   = 2'd2,
    PH_REPEAT = 2'd3
  } phase_t;

  typedef enum logic [CODE_W-1:0] {
    EV_SHORT_PRESS   = 3'd0,
    EV_SHORT_RELEASE = 3'd1,
    EV_LONG_PRESS    = 3'd2,
    EV_LONG_REPEAT   = 3'd3,
    EV_LONG_RELEASE  = 3'd4
  } event_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_TICKS  = 3'd0,
    REG_LONG_TICKS   = 3'd1,
    REG_GAP_TICKS    = 3'd2,
    REG_MULTI_PRESS  = 3'd3,
    REG_LONG_REPEAT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [TICK_W-1:0] short_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic              multi_press;
    logic              long_repeat;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [TICK_W-1:0]  hold;
    logic [TICK_W-1:0]  repeat_point;
    logic [CLICK_W-1:0] clicks;
    logic [TICK_W-1:0]  release_count;
  } key_state_t;

  typedef struct packed {
    logic               wr_en;
    key_state_t         state;
    logic               emit;
    event_code_t        code;
    logic [CLICK_W-1:0] count;
  } update_t;

endpackage

`default_nettype wire

[hdl/bpc_if.sv]
// Valid/ready channel interfaces for samples, events and register writes.
// Depends on bpc_pkg for field widths.
`default_nettype none

interface bpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::KEY_W-1:0]  key_index;
  logic                       pin_level;
  modport source (output valid, output key_index, output pin_level, input ready);
  modport sink   (input valid, input key_index, input pin_level, output ready);
endinterface

interface bpc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bpc_pkg::KEY_W-1:0]   event_key;
  logic [bpc_pkg::CODE_W-1:0]  event_code;
  logic [bpc_pkg::CLICK_W-1:0] click_count;
  modport source (output valid, output event_key, output event_code,
                  output click_count, input ready);
  modport sink   (input valid, input event_key, input event_code,
                  input click_count, output ready);
endinterface

interface bpc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]  index;
  logic [bpc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/bpc_cfg_regs.sv]
// Configuration register file for the button press classifier.
// Depends on bpc_pkg and the bpc_cfg_if interface.
`default_nettype none

module bpc_cfg_regs (
  input  wire logic     clk,
  input  wire logic     rst,
  bpc_cfg_if.sink       cfg,
  output bpc_pkg::cfg_t regs
);

  // Writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_ticks <= bpc_pkg::SHORT_TICKS_RST;
      regs.long_ticks  <= bpc_pkg::LONG_TICKS_RST;
      regs.gap_ticks   <= bpc_pkg::GAP_TICKS_RST;
      regs.multi_press <= 1'b0;
      regs.long_repeat <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bpc_pkg::REG_SHORT_TICKS: regs.short_ticks <= cfg.data;
        bpc_pkg::REG_LONG_TICKS:  regs.long_ticks  <= cfg.data;
        bpc_pkg::REG_GAP_TICKS:   regs.gap_ticks   <= cfg.data;
        bpc_pkg::REG_MULTI_PRESS: regs.multi_press <= cfg.data[0];
        bpc_pkg::REG_LONG_REPEAT: regs.long_repeat <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/bpc_key_bank.sv]
// Per-key state words held in flip-flops, one read and one write port.
// Depends on bpc_pkg for the state word layout.
`default_nettype none

module bpc_key_bank #(
  parameter int DEPTH = bpc_pkg::KEYS_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [IDX_W-1:0] rd_idx,
  output bpc_pkg::key_state_t rd_state,
  input  wire logic           wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire bpc_pkg::key_state_t wr_state
);

  bpc_pkg::key_state_t entry [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) begin
        entry[k] <= '0;
      end
    end else if (wr_en) begin
      entry[wr_idx] <= wr_state;
    end
  end

  assign rd_state = entry[rd_idx];

endmodule

`default_nettype wire

[hdl/bpc_classify.sv]
// Next-state and event logic for one key sample.
// Depends on bpc_pkg for the state, config and update structs.
`default_nettype none

module bpc_classify (
  input  wire logic                key_ok,
  input  wire logic                pin_level,
  input  wire bpc_pkg::key_state_t cur,
  input  wire bpc_pkg::cfg_t       regs,
  output bpc_pkg::update_t         upd
);

  logic [bpc_pkg::TICK_W-1:0] hold_inc;
  logic [bpc_pkg::TICK_W-1:0] rel_inc;

  assign hold_inc = bpc_pkg::TICK_W'(cur.hold + 1'b1);
  assign rel_inc  = bpc_pkg::TICK_W'(cur.release_count + 1'b1);

  always_comb begin
    upd.wr_en = key_ok;
    upd.state = cur;
    upd.emit  = 1'b0;
    upd.code  = bpc_pkg::EV_SHORT_PRESS;
    upd.count = '0;

    if (!pin_level) begin
      // Pressed: the hold counter advances, then the first matching rule wins.
      upd.state.hold = hold_inc;
      if (cur.phase == bpc_pkg::PH_LONG) begin
        if (regs.long_repeat) begin
          upd.state.phase        = bpc_pkg::PH_REPEAT;
          upd.state.repeat_point = bpc_pkg::TICK_W'(hold_inc + regs.long_ticks);
        end
      end else if (cur.phase == bpc_pkg::PH_REPEAT && cur.repeat_point == hold_inc) begin
        upd.state.repeat_point = bpc_pkg::TICK_W'(hold_inc + regs.long_ticks);
        if (regs.long_repeat) begin
          upd.emit = 1'b1;
          upd.code = bpc_pkg::EV_LONG_REPEAT;
        end
      end else if (hold_inc == regs.long_ticks) begin
        upd.state.phase = bpc_pkg::PH_LONG;
        upd.emit        = 1'b1;
        upd.code        = bpc_pkg::EV_LONG_PRESS;
      end else if (hold_inc == regs.short_ticks) begin
        upd.state.phase = bpc_pkg::PH_SHORT;
        if (regs.multi_press) begin
          upd.state.clicks        = bpc_pkg::CLICK_W'(cur.clicks + 1'b1);
          upd.state.release_count = '0;
        end
        upd.emit = 1'b1;
        upd.code = bpc_pkg::EV_SHORT_PRESS;
      end
    end else begin
      // Released: a short release may wait out the multi-click gap.
      if (cur.phase == bpc_pkg::PH_SHORT) begin
        if (regs.multi_press) begin
          upd.state.release_count = rel_inc;
        end
        if (!regs.multi_press || rel_inc > regs.gap_ticks) begin
          upd.emit                = 1'b1;
          upd.code                = bpc_pkg::EV_SHORT_RELEASE;
          upd.count               = cur.clicks;
          upd.state.clicks        = '0;
          upd.state.release_count = '0;
          upd.state.phase         = bpc_pkg::PH_IDLE;
        end
      end else if (cur.phase == bpc_pkg::PH_LONG || cur.phase == bpc_pkg::PH_REPEAT) begin
        upd.emit                = 1'b1;
        upd.code                = bpc_pkg::EV_LONG_RELEASE;
        upd.state.clicks        = '0;
        upd.state.release_count = '0;
        upd.state.phase         = bpc_pkg::PH_IDLE;
      end
      upd.state.hold = '0;
    end

    if (!key_ok) begin
      upd.emit = 1'b0;
    end
  end

endmodule

`default_nettype wire

[hdl/button_press_classifier_unit.sv]
// Button press classifier: short/long press, repeat and multi-click events per key.
// An accepted sample is held in the input register; its event is registered in the result register.
// Throughput: one sample per cycle, unless the event port stalls the result register.
// Reset: synchronous, clears all key states, restores register defaults at once.
// Depends on bpc_pkg, the bpc_if interfaces, bpc_cfg_regs, bpc_key_bank, bpc_classify.
`default_nettype none

`include "button_press_classifier_unit_defines.svh"

module button_press_classifier_unit #(
  parameter int KEYS = bpc_pkg::KEYS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  bpc_in_if.sink    samples,
  bpc_out_if.source events,
  bpc_cfg_if.sink   cfg
);

  // The key index is only three bits wide, so no more than eight keys can be
  // addressed; the state bank holds only the reachable entries.
  localparam int MAX_KEYS = 1 << bpc_pkg::KEY_W;
  localparam int DEPTH    = (KEYS < MAX_KEYS) ? KEYS : MAX_KEYS;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bpc_pkg::cfg_t       regs;
  bpc_pkg::key_state_t cur_state;
  bpc_pkg::update_t    upd;

  // Input register: the sample being classified this cycle.
  logic                      s1_valid;
  logic [bpc_pkg::KEY_W-1:0] s1_key;
  logic                      s1_pin;

  // Result register feeding the event port.
  logic                        out_valid;
  logic [bpc_pkg::KEY_W-1:0]   out_key;
  bpc_pkg::event_code_t        out_code;
  logic [bpc_pkg::CLICK_W-1:0] out_count;

  logic             s1_advance;
  logic             key_ok;
  logic [IDX_W-1:0] key_idx;

  bpc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // The sample in the input register moves on when the result register is
  // free or is being emptied this cycle. A sample with no event simply
  // retires, so the result register only loads when there is something to say.
  assign s1_advance    = s1_valid && (!out_valid || events.ready);
  assign samples.ready = !s1_valid || s1_advance;

  // Samples for keys beyond the configured count are dropped without effect.
  assign key_ok  = (KEYS >= MAX_KEYS) || (int'(s1_key) < KEYS);
  assign key_idx = key_ok ? s1_key[IDX_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_key <= samples.key_index;
      s1_pin <= samples.pin_level;
    end
  end

  // Key state is read and written back in the same cycle, so a sample of the
  // same key right behind sees the updated word without any forwarding.
  bpc_key_bank #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_bank (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (key_idx),
    .rd_state (cur_state),
    .wr_en    (s1_advance && upd.wr_en),
    .wr_idx   (key_idx),
    .wr_state (upd.state)
  );

  bpc_classify u_classify (
    .key_ok    (key_ok),
    .pin_level (s1_pin),
    .cur       (cur_state),
    .regs      (regs),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && !events.ready) || (s1_advance && upd.emit);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && upd.emit) begin
      out_key   <= s1_key;
      out_code  <= upd.code;
      out_count <= upd.count;
    end
  end

  assign events.valid       = out_valid;
  assign events.event_key   = out_key;
  assign events.event_code  = out_code;
  assign events.click_count = out_count;

  // A blocked sample must hold back the sample port.
  `BPC_ASSERT_NOW(a_stall_blocks_input, clk, rst,
    s1_valid && out_valid && !events.ready, !samples.ready,
    "sample accepted while the input register is blocked")

  // A blocked sample stays in the input register unchanged.
  `BPC_ASSERT_NEXT(a_input_reg_holds, clk, rst,
    s1_valid && !s1_advance, s1_valid && $stable(s1_key) && $stable(s1_pin),
    "input register changed while blocked")

  // Only a short release carries a click count.
  `BPC_ASSERT_NOW(a_count_only_on_release, clk, rst,
    out_valid && out_code != bpc_pkg::EV_SHORT_RELEASE, out_count == '0,
    "click count on an event other than a short release")

endmodule

`default_nettype wire

[sim/button_press_classifier_unit_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the button press classifier: follows register writes and key
// samples, predicts each event beat and checks it on the event channel.
// Depends on bpc_pkg and the bpc_if interfaces.

module button_press_classifier_unit_checker #(
  parameter int KEYS = bpc_pkg::KEYS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  bpc_in_if    samples,
  bpc_out_if   events,
  bpc_cfg_if   cfg,
  output int   mismatches,
  output int   outstanding
);
  import bpc_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    event_code_t        code;
    logic [CLICK_W-1:0] count;
  } key_event_t;

  // Register copy.
  logic [TICK_W-1:0] short_t;
  logic [TICK_W-1:0] long_t;
  logic [TICK_W-1:0] gap_t;
  logic              multi_on;
  logic              repeat_on;

  // Per-key state copy.
  phase_t             key_ph    [KEYS];
  logic [TICK_W-1:0]  held      [KEYS];
  logic [TICK_W-1:0]  next_rep  [KEYS];
  logic [CLICK_W-1:0] click_cnt [KEYS];
  logic [TICK_W-1:0]  rel_cnt   [KEYS];

  key_event_t due_events[$];

  // Advances one key by one sample and queues the event it raises, if any.
  task automatic classify_sample(input logic [KEY_W-1:0] k, input logic level);
    logic [TICK_W-1:0] h;
    key_event_t        ev;
    logic              fires;
    logic              done;
    if (int'(k) >= KEYS) return;
    fires    = 1'b0;
    ev.key   = k;
    ev.code  = EV_SHORT_PRESS;
    ev.count = '0;
    if (level == 1'b0) begin
      h       = held[k] + 1'b1;
      held[k] = h;
      if (key_ph[k] == PH_LONG) begin
        if (repeat_on) begin
          key_ph[k]   = PH_REPEAT;
          next_rep[k] = h + long_t;
        end
      end else if (key_ph[k] == PH_REPEAT && next_rep[k] == h) begin
        next_rep[k] = h + long_t;
        if (repeat_on) begin
          fires   = 1'b1;
          ev.code = EV_LONG_REPEAT;
        end
      end else if (h == long_t) begin
        key_ph[k] = PH_LONG;
        fires     = 1'b1;
        ev.code   = EV_LONG_PRESS;
      end else if (h == short_t) begin
        key_ph[k] = PH_SHORT;
        if (multi_on) begin
          click_cnt[k] = click_cnt[k] + 1'b1;
          rel_cnt[k]   = '0;
        end
        fires   = 1'b1;
        ev.code = EV_SHORT_PRESS;
      end
    end else begin
      if (key_ph[k] == PH_SHORT) begin
        done = 1'b1;
        if (multi_on) begin
          rel_cnt[k] = rel_cnt[k] + 1'b1;
          done       = rel_cnt[k] > gap_t;
        end
        if (done) begin
          fires        = 1'b1;
          ev.code      = EV_SHORT_RELEASE;
          ev.count     = click_cnt[k];
          click_cnt[k] = '0;
          rel_cnt[k]   = '0;
          key_ph[k]    = PH_IDLE;
        end
      end else if (key_ph[k] == PH_LONG || key_ph[k] == PH_REPEAT) begin
        fires        = 1'b1;
        ev.code      = EV_LONG_RELEASE;
        click_cnt[k] = '0;
        rel_cnt[k]   = '0;
        key_ph[k]    = PH_IDLE;
      end
      held[k] = '0;
    end
    if (fires) due_events.push_back(ev);
  endtask

  always @(posedge clk) begin : track
    key_event_t seen;
    key_event_t want;
    if (rst) begin
      short_t   = SHORT_TICKS_RST;
      long_t    = LONG_TICKS_RST;
      gap_t     = GAP_TICKS_RST;
      multi_on  = 1'b0;
      repeat_on = 1'b0;
      for (int i = 0; i < KEYS; i++) begin
        key_ph[i]    = PH_IDLE;
        held[i]      = '0;
        next_rep[i]  = '0;
        click_cnt[i] = '0;
        rel_cnt[i]   = '0;
      end
      due_events.delete();
      mismatches <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_SHORT_TICKS: short_t   = cfg.data;
          REG_LONG_TICKS:  long_t    = cfg.data;
          REG_GAP_TICKS:   gap_t     = cfg.data;
          REG_MULTI_PRESS: multi_on  = cfg.data[0];
          REG_LONG_REPEAT: repeat_on = cfg.data[0];
          default: ;
        endcase
      end
      if (samples.valid && samples.ready) begin
        classify_sample(samples.key_index, samples.pin_level);
      end
      if (events.valid && events.ready) begin
        seen.key   = events.event_key;
        seen.code  = event_code_t'(events.event_code);
        seen.count = events.click_count;
        if (due_events.size() == 0) begin
          $display("%0t: event beat with none due: expected none, %s %0d %s %0d %s %0d",
                   $time, "actual key", seen.key, "code", seen.code, "count", seen.count);
          mismatches <= mismatches + 1;
        end else begin
          want = due_events.pop_front();
          if (seen.key !== want.key || seen.code !== want.code ||
              seen.count !== want.count) begin
            $display("%0t: event beat differs: expected key %0d code %0d count %0d,",
                     $time, want.key, want.code, want.count,
                     " actual key %0d code %0d count %0d",
                     seen.key, seen.code, seen.count);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    outstanding <= due_events.size();
  end

endmodule

[sim/button_press_classifier_unit_tb.sv]
`timescale 1ns / 100ps
// Testbench top for button_press_classifier_unit: drives key samples and register
// writes, paces the event receiver and prints the verdict.
// Depends on bpc_pkg, the bpc_if interfaces, the DUT and the checker module.

module button_press_classifier_unit_tb;
  import bpc_pkg::*;

  localparam int   DUT_LATENCY  = 2;
  localparam int   RANDOM_BEATS = 180;
  localparam int   LONG_STALL   = 300;
  // No legal stretch without any beat comes near this: the longest is the
  // receiver hold-off.
  localparam int   QUIET_LIMIT  = 5000;
  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst;
  logic stall_request;
  int   mismatches;
  int   outstanding;
  int   beats_sent;
  int   burst_left;

  // Register values as last written; they only shape the stimulus.
  logic [TICK_W-1:0] cur_short;
  logic [TICK_W-1:0] cur_long;
  logic [TICK_W-1:0] cur_gap;

  bpc_in_if  samples_if ();
  bpc_out_if events_if ();
  bpc_cfg_if cfg_if ();

  button_press_classifier_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .events  (events_if),
    .cfg     (cfg_if)
  );

  button_press_classifier_unit_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples_if),
    .events      (events_if),
    .cfg         (cfg_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one sample and waits for its beat. The sender runs in bursts: once a
  // burst is used up, valid drops for a random gap and a new burst length is
  // drawn. Now and then a long burst gives a stretch with no idling at all.
  task automatic send_sample(input logic [KEY_W-1:0] k, input logic level);
    samples_if.valid     <= 1'b1;
    samples_if.key_index <= k;
    samples_if.pin_level <= level;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(100, 300))
                                                : int'($urandom_range(0, 24));
    end
  endtask

  task automatic hold_then_release(input logic [KEY_W-1:0] k, input int hold_n,
                                   input int release_n);
    repeat (hold_n) send_sample(k, PIN_PRESSED);
    repeat (release_n) send_sample(k, PIN_RELEASED);
  endtask

  // Stops the sender and waits until every predicted event has arrived. Samples
  // that raise no event may still be in the pipe then, so the task waits on
  // before the block counts as idle.
  task automatic wait_for_events();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DUT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Writes all five registers back to back while the block is idle. The one-bit
  // registers get random upper data bits, which the block must drop, and one
  // write goes to an index past the last register, which it must ignore.
  task automatic apply_settings(input logic [TICK_W-1:0] short_v,
                                input logic [TICK_W-1:0] long_v,
                                input logic [TICK_W-1:0] gap_v, input logic multi_v,
                                input logic repeat_v);
    wait_for_events();
    write_reg(REG_SHORT_TICKS, short_v);
    write_reg(REG_LONG_TICKS, long_v);
    write_reg(REG_GAP_TICKS, gap_v);
    write_reg(REG_MULTI_PRESS, {15'($urandom), multi_v});
    write_reg(REG_LONG_REPEAT, {15'($urandom), repeat_v});
    write_reg(REG_LONG_REPEAT + 3'($urandom_range(1, 3)), 16'($urandom));
    cfg_if.valid <= 1'b0;
    cur_short = short_v;
    cur_long  = long_v;
    cur_gap   = gap_v;
  endtask

  // Small thresholds so that every phase of a key is reached within a few
  // dozen samples; the long threshold may fall at or below the short one.
  task automatic apply_random_settings();
    apply_settings(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)),
                   16'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
  endtask

  // One sequence on one key, sized from the current thresholds: a run of
  // clicks, a hold that stops near the long threshold, or a hold that goes
  // well past it. Some sequences are only noise on random keys, which also
  // breaks into sequences left open on other keys.
  task automatic random_sequence();
    logic [KEY_W-1:0] k;
    int short_span;
    int long_span;
    int gap_span;
    int n;
    k          = KEY_W'($urandom_range(0, KEYS_DEFAULT - 1));
    short_span = (cur_short < 16'd8) ? int'(cur_short) : 8;
    long_span  = (cur_long < 16'd16) ? int'(cur_long) : 16;
    gap_span   = (cur_gap < 16'd8) ? int'(cur_gap) : 8;
    case ($urandom_range(0, 9))
      0, 1: begin
        repeat ($urandom_range(1, 6))
          send_sample(KEY_W'($urandom_range(0, KEYS_DEFAULT - 1)),
                      1'($urandom_range(0, 1)));
      end
      2, 3, 4: begin
        n = $urandom_range(1, 3);
        for (int c = 0; c < n; c++) begin
          hold_then_release(k, $urandom_range(1, short_span + 1),
                            (c == n - 1) ? gap_span + 2 : $urandom_range(1, gap_span + 1));
        end
      end
      5, 6: begin
        hold_then_release(k, $urandom_range((long_span > 1) ? long_span - 1 : 1, long_span + 1),
                          $urandom_range(1, 2));
      end
      default: begin
        hold_then_release(k, $urandom_range(1, 3 * long_span + 2), $urandom_range(1, 3));
      end
    endcase
  endtask

  // Event receiver. Its stall pattern switches between steady, coin-flip,
  // sparse and periodic modes. On request it holds ready low for a long
  // stretch, counted here, so that the block backs up into its input.
  initial begin : event_receiver
    rx_mode_t mode;
    int mode_left;
    int tick;
    events_if.ready <= 1'b0;
    mode      = RX_STEADY;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (stall_request) begin
        events_if.ready <= 1'b0;
        stall_request   <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        RX_STEADY:   events_if.ready <= 1'b1;
        RX_COIN:     events_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   events_if.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: events_if.ready <= (tick % 5 != 0);
        default:     events_if.ready <= 1'b1;
      endcase
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (samples_if.valid && samples_if.ready) ||
          (events_if.valid && events_if.ready) || (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("button_press_classifier_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    int phase_end;
    samples_if.valid     <= 1'b0;
    samples_if.key_index <= '0;
    samples_if.pin_level <= PIN_RELEASED;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_SHORT_TICKS;
    cfg_if.data          <= '0;
    stall_request        <= 1'b0;
    rst                  <= 1'b1;
    beats_sent = 0;
    burst_left = 0;
    cur_short  = SHORT_TICKS_RST;
    cur_long   = LONG_TICKS_RST;
    cur_gap    = GAP_TICKS_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Register defaults straight out of reset: a short click on the lowest and
    // the highest key, and a release on a key that was never pressed.
    hold_then_release(3'd0, 2, 1);
    hold_then_release(3'd7, 2, 1);
    send_sample(3'd1, PIN_RELEASED);

    // Tiny thresholds with multi-click and repeat on: one hold that walks
    // through short press, long press and a repeat, then a double click whose
    // first release stays inside the gap and whose second one ends the run.
    apply_settings(16'd1, 16'd3, 16'd1, 1'b1, 1'b1);
    hold_then_release(3'd2, 7, 1);
    hold_then_release(3'd3, 1, 1);
    hold_then_release(3'd3, 1, 2);

    // A key held into the long phase with repeat off, then repeat switched on
    // while it is still down, then off again while it is repeating, so the
    // repeat point advances without an event.
    apply_settings(16'd1, 16'd3, 16'd1, 1'b0, 1'b0);
    hold_then_release(3'd4, 5, 0);
    apply_settings(16'd1, 16'd3, 16'd1, 1'b0, 1'b1);
    hold_then_release(3'd4, 4, 0);
    apply_settings(16'd1, 16'd3, 16'd1, 1'b0, 1'b0);
    hold_then_release(3'd4, 3, 1);

    // Back-pressure: every sample below raises an event, and the receiver
    // holds off for a long stretch while the sender keeps offering beats.
    apply_settings(16'd1, 16'hFFFF, 16'd0, 1'b0, 1'b0);
    burst_left = 400;
    stall_request <= 1'b1;
    for (int j = 0; j < 60; j++) hold_then_release(KEY_W'(j % KEYS_DEFAULT), 1, 1);

    // Random phases, each with fresh small thresholds.
    random_start = beats_sent;
    while (beats_sent - random_start < RANDOM_BEATS) begin
      apply_random_settings();
      phase_end = beats_sent + 90;
      while (beats_sent < phase_end) random_sequence();
    end

    // Corner settings: both thresholds at one (the long rule wins), short above
    // long, a zero release gap with multi-click, and every register at its top.
    apply_settings(16'd1, 16'd1, 16'd0, 1'b1, 1'b1);
    repeat (12) random_sequence();
    apply_settings(16'd6, 16'd3, 16'd2, 1'b1, 1'b1);
    repeat (12) random_sequence();
    apply_settings(16'd2, 16'd9, 16'd0, 1'b1, 1'b0);
    repeat (12) random_sequence();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    repeat (6) random_sequence();

    wait_for_events();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("button_press_classifier_unit: match");
    end else begin
      $display("button_press_classifier_unit: mismatch");
    end
    $finish;
  end

endmodule
